// ===== sv/gha_pkg.sv =====
// Shared types and codes of the generational handle allocator.
// No dependencies.
package gha_pkg;

	typedef enum logic [2:0] {
		MODE_CREATE  = 3'd0,
		MODE_DESTROY = 3'd1,
		MODE_PROCESS = 3'd2,
		MODE_CHECK   = 3'd3,
		MODE_DESTROY_ALL = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_GRANTED   = 3'd0,
		KIND_CREATED   = 3'd1,
		KIND_DESTROYED = 3'd2,
		KIND_VALIDITY  = 3'd3,
		KIND_REJECTED  = 3'd4,
		KIND_DONE      = 3'd5
	} kind_t;

	localparam int unsigned CAPACITY = 64;
	localparam int unsigned VERSION_BITS = 16;
	localparam int unsigned ID_W = $clog2(CAPACITY) + 1;
	localparam int unsigned GEN_W = VERSION_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_WALK_RD,
		ST_WALK_EX,
		ST_WALK_END,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [ID_W-1:0]  handle_id;
		logic [GEN_W-1:0] handle_gen;
		logic             finalize_ok;
	} in_word_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [ID_W-1:0]  out_id;
		logic [GEN_W-1:0] out_gen;
		logic             is_valid;
		logic [ID_W-1:0]  live_count;
		logic             last;
	} out_word_t;

endpackage

// ===== sv/gha_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on gha_pkg.
interface gha_in_if import gha_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gha_out_if import gha_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/gha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gha_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/generational_handle_allocator.sv =====
// Generational handle allocator: slot map with FIFO free list and command queue.
// Depends on gha_pkg, gha_if, gha_ram.
//
// Usage:
//  - req (sink): one word per operation: mode, handle_id, handle_gen, finalize_ok.
//  - rsp (source): result words; last marks the final word of a request.
// One request is handled at a time. Create, destroy and check pass a read
// state on the slot and queue memories and an execute state that writes back
// and loads the result register; the next request is taken the cycle after
// the result word leaves. Process reads the command word, then its slot,
// before executing; on an empty queue it answers after the command read.
// Unknown modes and a refused destroy-all answer from the read state.
// Destroy-all passes the read state, a read and an execute state per used
// slot and a closing state; each destroyed word is held until the next valid
// slot turns up or the walk ends.
// Slot versions and flags sit in one memory; per-slot valid bits give the
// zero reset, so reset takes effect at once with no clearing pass.
// When the receiver stalls, the result register holds its word and the
// block takes no new request and does not advance a walk.
module generational_handle_allocator
	import gha_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	gha_in_if.sink    req,
	gha_out_if.source rsp
);
	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned QW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = IW + 1;
	localparam int unsigned FW = QW + 1;
	localparam int unsigned SW = VERSION_BITS + 3;
	localparam int unsigned CMW = 1 + IW + VERSION_BITS;

	// slot word: {flags[2:0] (destroy, active, valid), version}
	logic           slot_we;
	logic [IW-1:0]  slot_wa, slot_ra;
	logic [SW-1:0]  slot_wd, slot_rd;
	logic [CAPACITY-1:0] written_q;
	logic           nf_we;
	logic [IW-1:0]  nf_wa, nf_ra, nf_wd, nf_rd;
	logic           cq_we;
	logic [QW-1:0]  cq_wa, cq_ra;
	logic [CMW-1:0] cq_wd, cq_rd;

	gha_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot (
		.clk, .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
		.raddr(slot_ra), .rdata(slot_rd));
	gha_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
		.clk, .we(nf_we), .waddr(nf_wa), .wdata(nf_wd),
		.raddr(nf_ra), .rdata(nf_rd));
	gha_ram #(.WIDTH(CMW), .DEPTH(QUEUE_DEPTH)) u_cmdq (
		.clk, .we(cq_we), .waddr(cq_wa), .wdata(cq_wd),
		.raddr(cq_ra), .rdata(cq_rd));

	state_t state_q, state_d;
	in_word_t  in_q;
	out_word_t out_q, out_d;
	out_word_t pend_q, pend_d;
	logic      out_v_q, out_load;
	logic [IW-1:0] free_head_q, free_tail_q, rd_idx_q, walk_q;
	logic      free_empty_q, any_q, rd_wr_q;
	logic [CW-1:0] used_q, active_q;
	logic [QW-1:0] rp_q, wp_q;
	logic [FW-1:0] fill_q;

	// next-cycle register values
	logic [IW-1:0] free_head_d, free_tail_d, walk_d, rd_idx_d;
	logic          free_empty_d, any_d;
	logic [CW-1:0] used_d, active_d;
	logic [QW-1:0] rp_d, wp_d;
	logic [FW-1:0] fill_d;

	// decoded read data
	logic [VERSION_BITS-1:0] s_ver;
	logic [2:0]    s_flg;
	logic          c_dst;
	logic [IW-1:0] c_idx;
	logic [VERSION_BITS-1:0] c_ver;
	logic          hv, stale, rd_go;

	assign s_ver = rd_wr_q ? slot_rd[VERSION_BITS-1:0] : '0;
	assign s_flg = rd_wr_q ? slot_rd[SW-1:VERSION_BITS] : 3'b000;
	assign {c_dst, c_idx, c_ver} = cq_rd;
	assign hv = (in_q.handle_id != '0) && (in_q.handle_id <= used_q)
		&& s_flg[0] && !s_flg[2]
		&& (s_ver == in_q.handle_gen);
	assign stale = ({1'b0, c_idx} >= used_q) || !s_flg[0] || (s_ver != c_ver);

	assign req.ready = (state_q == ST_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;
	assign rd_go = !out_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			free_head_q <= '0;
			free_tail_q <= '0;
			free_empty_q <= 1'b1;
			used_q <= '0;
			active_q <= '0;
			rp_q <= '0;
			wp_q <= '0;
			fill_q <= '0;
			walk_q <= '0;
			any_q <= 1'b0;
			written_q <= '0;
		end else begin
			state_q <= state_d;
			free_head_q <= free_head_d;
			free_tail_q <= free_tail_d;
			free_empty_q <= free_empty_d;
			used_q <= used_d;
			active_q <= active_d;
			rp_q <= rp_d;
			wp_q <= wp_d;
			fill_q <= fill_d;
			walk_q <= walk_d;
			any_q <= any_d;
			if (slot_we) begin
				written_q[slot_wa] <= 1'b1;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			in_q <= req.data;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		pend_q <= pend_d;
		rd_idx_q <= rd_idx_d;
		rd_wr_q <= written_q[rd_idx_d];
	end

	function automatic out_word_t mk(kind_t k, logic [ID_W-1:0] id,
			logic [GEN_W-1:0] g, logic v, logic [CW-1:0] live, logic lst);
		out_word_t o;
		o.kind = k;
		o.out_id = id;
		o.out_gen = g;
		o.is_valid = v;
		o.live_count = ID_W'(live);
		o.last = lst;
		return o;
	endfunction

	always_comb begin
		logic [IW-1:0] idx;
		logic [CW-1:0] idp1;
		state_d = state_q;
		free_head_d = free_head_q;
		free_tail_d = free_tail_q;
		free_empty_d = free_empty_q;
		used_d = used_q;
		active_d = active_q;
		rp_d = rp_q;
		wp_d = wp_q;
		fill_d = fill_q;
		walk_d = walk_q;
		any_d = any_q;
		pend_d = pend_q;
		rd_idx_d = rd_idx_q;
		out_load = 1'b0;
		out_d = mk(KIND_REJECTED, '0, '0, 1'b0, active_q, 1'b1);
		slot_we = 1'b0;
		slot_wa = rd_idx_q;
		slot_wd = '0;
		nf_we = 1'b0;
		nf_wa = free_tail_q;
		nf_wd = '0;
		nf_ra = free_head_q;
		cq_we = 1'b0;
		cq_wa = wp_q;
		cq_wd = '0;
		cq_ra = rp_q;
		idx = '0;
		idp1 = '0;
		slot_ra = rd_idx_d;
		case (state_q)
			ST_IDLE: begin
				if (req.valid && req.ready) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				// choose slot to read for this request
				case (in_q.mode)
					MODE_CREATE:  rd_idx_d = free_empty_q ? IW'(used_q) : free_head_q;
					MODE_DESTROY, MODE_CHECK: rd_idx_d = IW'(in_q.handle_id - 1'b1);
					MODE_PROCESS: rd_idx_d = rd_idx_q;
					default:      rd_idx_d = '0;
				endcase
				if (in_q.mode == MODE_DESTROY_ALL) begin
					if (fill_q != '0) begin
						out_load = 1'b1;
						state_d = ST_IDLE;
					end else begin
						active_d = '0;
						walk_d = '0;
						any_d = 1'b0;
						state_d = ST_WALK_RD;
					end
				end else if (in_q.mode == MODE_PROCESS) begin
					// command word first, slot afterwards
					state_d = ST_OUT;
				end else if (in_q.mode > MODE_DESTROY_ALL) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_EXEC;
				end
				slot_ra = rd_idx_d;
			end
			ST_OUT: begin
				// queue head now available; read its slot
				rd_idx_d = c_idx;
				slot_ra = c_idx;
				if (fill_q == '0) begin
					out_d = mk(KIND_DONE, '0, '0, 1'b0, active_q, 1'b1);
					out_load = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				idx = rd_idx_q;
				idp1 = CW'(idx) + 1'b1;
				state_d = ST_IDLE;
				out_load = 1'b1;
				case (in_q.mode)
					MODE_CREATE: begin
						if (fill_q >= FW'(QUEUE_DEPTH)
								|| (free_empty_q && used_q >= CW'(CAPACITY))) begin
							out_d = mk(KIND_REJECTED, '0, '0, 1'b0, active_q, 1'b1);
						end else begin
							if (free_empty_q) begin
								used_d = used_q + 1'b1;
							end else if (free_head_q == free_tail_q) begin
								free_empty_d = 1'b1;
							end else begin
								free_head_d = nf_rd;
							end
							slot_we = 1'b1;
							slot_wd = {s_flg | 3'b001, s_ver};
							cq_we = 1'b1;
							cq_wd = {1'b0, idx, s_ver};
							wp_d = wp_q + 1'b1;
							fill_d = fill_q + 1'b1;
							out_d = mk(KIND_GRANTED, ID_W'(idp1), GEN_W'(s_ver), 1'b0,
								active_q, 1'b1);
						end
					end
					MODE_DESTROY: begin
						if (fill_q >= FW'(QUEUE_DEPTH) || !hv) begin
							out_d = mk(KIND_REJECTED, in_q.handle_id, in_q.handle_gen,
								1'b0, active_q, 1'b1);
						end else begin
							slot_we = 1'b1;
							slot_wd = {s_flg | 3'b100, s_ver};
							cq_we = 1'b1;
							cq_wd = {1'b1, idx, s_ver};
							wp_d = wp_q + 1'b1;
							fill_d = fill_q + 1'b1;
							out_d = mk(KIND_DONE, in_q.handle_id, in_q.handle_gen,
								1'b0, active_q, 1'b1);
						end
					end
					MODE_CHECK: begin
						out_d = mk(KIND_VALIDITY, in_q.handle_id, in_q.handle_gen,
							hv, active_q, 1'b1);
					end
					default: begin
						// process a queued command
						rp_d = rp_q + 1'b1;
						fill_d = fill_q - 1'b1;
						if (stale) begin
							out_d = mk(KIND_REJECTED, ID_W'(idp1), GEN_W'(c_ver), 1'b0,
								active_q, 1'b1);
						end else if (!c_dst) begin
							if (!in_q.finalize_ok) begin
								if (!s_flg[2]) begin
									slot_we = 1'b1;
									slot_wd = {s_flg | 3'b100, s_ver};
									cq_we = 1'b1;
									cq_wd = {1'b1, idx, s_ver};
									wp_d = wp_q + 1'b1;
									fill_d = fill_q;
								end
								out_d = mk(KIND_REJECTED, ID_W'(idp1), GEN_W'(c_ver),
									1'b0, active_q, 1'b1);
							end else begin
								if (!s_flg[1]) begin
									slot_we = 1'b1;
									slot_wd = {s_flg | 3'b010, s_ver};
									active_d = active_q + 1'b1;
								end
								out_d = mk(KIND_CREATED, ID_W'(idp1), GEN_W'(c_ver),
									1'b0, active_d, 1'b1);
							end
						end else begin
							if (s_flg[1] && active_q != '0) begin
								active_d = active_q - 1'b1;
							end
							slot_we = 1'b1;
							slot_wd = {3'b000, s_ver + 1'b1};
							if (free_empty_q) begin
								free_head_d = idx;
								free_empty_d = 1'b0;
							end else begin
								nf_we = 1'b1;
								nf_wd = idx;
							end
							free_tail_d = idx;
							out_d = mk(KIND_DESTROYED, ID_W'(idp1), GEN_W'(c_ver), 1'b0,
								active_d, 1'b1);
						end
					end
				endcase
			end
			ST_WALK_RD: begin
				rd_idx_d = walk_q;
				slot_ra = walk_q;
				if (used_q == '0) begin
					out_d = mk(KIND_DONE, '0, '0, 1'b0, '0, 1'b1);
					out_load = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_WALK_EX;
				end
			end
			ST_WALK_EX: begin
				idx = rd_idx_q;
				idp1 = CW'(idx) + 1'b1;
				if (rd_go) begin
					// relink the free list in slot order
					nf_we = (idp1 < used_q);
					nf_wa = idx;
					nf_wd = IW'(idp1);
					if (s_flg[0]) begin
						slot_we = 1'b1;
						slot_wd = {3'b000, s_ver + 1'b1};
						// held word is not the last one: send it, hold this slot's
						if (any_q) begin
							out_load = 1'b1;
							out_d = pend_q;
						end
						any_d = 1'b1;
						pend_d = mk(KIND_DESTROYED, ID_W'(idp1), GEN_W'(s_ver), 1'b0,
							'0, 1'b0);
					end
					if (idp1 == used_q) begin
						free_head_d = '0;
						free_tail_d = idx;
						free_empty_d = 1'b0;
						state_d = ST_WALK_END;
					end else begin
						walk_d = walk_q + 1'b1;
						state_d = ST_WALK_RD;
					end
				end
			end
			ST_WALK_END: begin
				if (rd_go) begin
					out_load = 1'b1;
					if (any_q) begin
						out_d = pend_q;
						out_d.last = 1'b1;
					end else begin
						out_d = mk(KIND_DONE, '0, '0, 1'b0, '0, 1'b1);
					end
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(QUEUE_DEPTH))
		else $error("command queue overfilled");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(CAPACITY))
		else $error("slot count beyond capacity");
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_READ))
		else $error("accepted word not started");
	a_active_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= used_q)
		else $error("active count above used slots");
`endif
endmodule
